// ----- design/mcnr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcnr_pkg
// Shared types and constants of the chord-note reference counter.
// ----------------------------------------------------------------------------
package mcnr_pkg;

	localparam int LANES      = 4;
	localparam int NOTES      = 128;
	localparam int DEPTH      = LANES * NOTES;
	localparam int ADDR_W     = $clog2(DEPTH);
	localparam int CHAN_REGS  = 4;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_ROOT_NOTE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VEL_SCALE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LANE0_CH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LANE1_CH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LANE2_CH  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LANE3_CH  = 3'd5;

	localparam logic [7:0] NOTE_OFF_STATUS = 8'h80;
	localparam logic [7:0] NOTE_ON_STATUS  = 8'h90;
	localparam logic [6:0] NOTE_MIN        = 7'd12;
	localparam logic [6:0] NOTE_MAX        = 7'd127;
	localparam logic [6:0] VEL_MIN         = 7'd1;
	localparam logic [6:0] VEL_MAX         = 7'd127;
	localparam logic [7:0] CNT_MAX         = 8'd255;
	localparam logic       CMD_PLAY        = 1'b0;
	localparam logic       CMD_STOP        = 1'b1;

	typedef logic [4:0] chan_t;

	typedef struct packed {
		logic              cmd;
		logic              lane_ok;
		logic              audible;
		logic [3:0]        chan;
		logic [6:0]        note;
		logic [ADDR_W-1:0] addr;
		logic [14:0]       product;
		logic signed [8:0] offs_sum;
	} req_t;

	typedef struct packed {
		logic       last;
		logic [6:0] velocity;
		logic [6:0] note;
		logic [7:0] status;
	} msg_t;

endpackage

// ----- design/midi_chord_note_refcount.sv -----
`timescale 1ns / 1ps
// Messages of a request are built from the registered request and the registered counter read.
// A new request is taken only after the read-modify-write of the counter RAM for the last one.
// Messages queue in a 4-entry FIFO; s_tready drops while fewer than two slots are free.
// Reset: asynchronous, active low; config registers return to their defaults and a
// clearing pass zeroes the 512 counters, one per cycle, with s_tready low until it ends.
// ----------------------------------------------------------------------------
// midi_chord_note_refcount
// Chord-note play/stop requests to MIDI note-on/off messages with per-lane,
// per-note saturating sounding counts.
// ----------------------------------------------------------------------------
module midi_chord_note_refcount (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [mcnr_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [mcnr_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// lane[1:0] interval[8:2] octave_shift[12:9] semitone_shift[17:13]
	// pad_velocity[24:18] velocity_offset[32:25] random_offset[40:33]
	input  logic [mcnr_pkg::IN_DATA_W-1:0]        s_tdata,
	input  logic                                  s_tuser, // command[0]
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [mcnr_pkg::OUT_DATA_W-1:0]       m_tdata, // msg_status[7:0] msg_note[14:8] msg_velocity[21:15]
	output logic                                  m_tlast
);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPD
	} state_t;

	state_t                                   state_q;
	logic [mcnr_pkg::ADDR_W-1:0]              clr_addr_q;
	logic [6:0]                               root_note_q;
	logic [7:0]                               vel_scale_q;
	mcnr_pkg::chan_t [mcnr_pkg::CHAN_REGS-1:0] lane_chan_q;

	logic                        accept;
	logic                        room2;
	logic [mcnr_pkg::ADDR_W-1:0] rd_addr;
	mcnr_pkg::req_t              req_s1;
	logic [7:0]                  cnt;
	logic                        mem_we;
	logic [mcnr_pkg::ADDR_W-1:0] mem_waddr;
	logic [7:0]                  mem_wdata;
	logic                        upd_we;
	logic [7:0]                  cnt_new;
	logic signed [16:0]          vel_sum;
	logic [6:0]                  vel;
	logic [1:0]                  push_n;
	mcnr_pkg::msg_t              push_a;
	mcnr_pkg::msg_t              push_b;
	logic [7:0]                  st_off;
	logic [7:0]                  st_on;

	assign s_tready = (state_q == ST_IDLE) & room2;
	assign accept   = s_tvalid & s_tready;

	mcnr_calc u_calc (
		.clk            (clk),
		.load           (accept),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.root_note      (root_note_q),
		.velocity_scale (vel_scale_q),
		.lane_chan      (lane_chan_q),
		.rd_addr        (rd_addr),
		.req_s1         (req_s1)
	);

	mcnr_count_mem u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (accept),
		.raddr (rd_addr),
		.rdata (cnt)
	);

	always_comb begin
		vel_sum = signed'({2'b00, req_s1.product})
			+ signed'({{2{req_s1.offs_sum[8]}}, req_s1.offs_sum, 6'b000000});
		if (vel_sum < 17'sd64) begin
			vel = mcnr_pkg::VEL_MIN;
		end else if (vel_sum[16:6] > 11'(mcnr_pkg::VEL_MAX)) begin
			vel = mcnr_pkg::VEL_MAX;
		end else begin
			vel = vel_sum[12:6];
		end
	end

	assign st_off = mcnr_pkg::NOTE_OFF_STATUS | {4'h0, req_s1.chan};
	assign st_on  = mcnr_pkg::NOTE_ON_STATUS | {4'h0, req_s1.chan};

	always_comb begin
		upd_we  = 1'b0;
		cnt_new = cnt;
		push_n  = 2'd0;
		push_a  = '{last: 1'b1, velocity: vel, note: req_s1.note, status: st_on};
		push_b  = '{last: 1'b1, velocity: vel, note: req_s1.note, status: st_on};
		if ((state_q == ST_UPD) && req_s1.lane_ok) begin
			if (req_s1.cmd == mcnr_pkg::CMD_PLAY) begin
				upd_we = 1'b1;
				if (cnt != mcnr_pkg::CNT_MAX) begin
					cnt_new = cnt + 8'd1;
				end
				if (req_s1.audible) begin
					if (cnt != 8'd0) begin
						push_n = 2'd2;
						push_a = '{last: 1'b0, velocity: vel, note: req_s1.note,
							status: st_off};
					end else begin
						push_n = 2'd1;
					end
				end
			end else if (cnt != 8'd0) begin
				upd_we  = 1'b1;
				cnt_new = cnt - 8'd1;
				if ((cnt == 8'd1) && req_s1.audible) begin
					push_n = 2'd1;
					push_a = '{last: 1'b1, velocity: 7'd0, note: req_s1.note,
						status: st_off};
				end
			end
		end
	end

	assign mem_we    = (state_q == ST_CLEAR) | upd_we;
	assign mem_waddr = (state_q == ST_CLEAR) ? clr_addr_q : req_s1.addr;
	assign mem_wdata = (state_q == ST_CLEAR) ? 8'd0 : cnt_new;

	mcnr_msg_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_n   (push_n),
		.push_a   (push_a),
		.push_b   (push_b),
		.room2    (room2),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + mcnr_pkg::ADDR_W'(1);
					if (clr_addr_q == mcnr_pkg::ADDR_W'(mcnr_pkg::DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_note_q    <= 7'd60;
			vel_scale_q    <= 8'd64;
			lane_chan_q[0] <= 5'd0;
			lane_chan_q[1] <= 5'd1;
			lane_chan_q[2] <= 5'd2;
			lane_chan_q[3] <= 5'd3;
		end else if (cfg_we) begin
			case (cfg_index)
				mcnr_pkg::REG_ROOT_NOTE: root_note_q    <= cfg_data[6:0];
				mcnr_pkg::REG_VEL_SCALE: vel_scale_q    <= cfg_data;
				mcnr_pkg::REG_LANE0_CH:  lane_chan_q[0] <= cfg_data[4:0];
				mcnr_pkg::REG_LANE1_CH:  lane_chan_q[1] <= cfg_data[4:0];
				mcnr_pkg::REG_LANE2_CH:  lane_chan_q[2] <= cfg_data[4:0];
				mcnr_pkg::REG_LANE3_CH:  lane_chan_q[3] <= cfg_data[4:0];
				default: begin
				end
			endcase
		end
	end

endmodule

// ----- design/mcnr_count_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcnr_count_mem
// Per-lane, per-note sounding counters; one write port, one registered read.
// ----------------------------------------------------------------------------
module mcnr_count_mem (
	input  logic                       clk,
	input  logic                       we,
	input  logic [mcnr_pkg::ADDR_W-1:0] waddr,
	input  logic [7:0]                 wdata,
	input  logic                       re,
	input  logic [mcnr_pkg::ADDR_W-1:0] raddr,
	output logic [7:0]                 rdata
);

	logic [7:0] mem [mcnr_pkg::DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- design/mcnr_calc.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcnr_calc
// Request front end: note arithmetic with clamp, counter address, channel
// lookup and velocity product, registered on accept.
// ----------------------------------------------------------------------------
module mcnr_calc (
	input  logic                                     clk,
	input  logic                                     load,
	input  logic [mcnr_pkg::IN_DATA_W-1:0]           s_tdata,
	input  logic                                     s_tuser,
	input  logic [6:0]                               root_note,
	input  logic [7:0]                               velocity_scale,
	input  mcnr_pkg::chan_t [mcnr_pkg::CHAN_REGS-1:0] lane_chan,
	output logic [mcnr_pkg::ADDR_W-1:0]              rd_addr,
	output mcnr_pkg::req_t                           req_s1
);

	logic [1:0]        lane;
	logic [6:0]        interval;
	logic [3:0]        oct;
	logic [4:0]        semis;
	logic [6:0]        padv;
	logic [7:0]        voff;
	logic [7:0]        vrnd;
	logic signed [9:0] oct_e;
	logic signed [9:0] n_sum;
	logic [6:0]        note;
	mcnr_pkg::chan_t   chan;

	assign lane     = s_tdata[1:0];
	assign interval = s_tdata[8:2];
	assign oct      = s_tdata[12:9];
	assign semis    = s_tdata[17:13];
	assign padv     = s_tdata[24:18];
	assign voff     = s_tdata[32:25];
	assign vrnd     = s_tdata[40:33];

	always_comb begin
		oct_e = signed'({{6{oct[3]}}, oct});
		n_sum = signed'({3'b000, root_note})
			+ signed'({{3{interval[6]}}, interval})
			+ (oct_e <<< 3) + (oct_e <<< 2)
			+ signed'({{5{semis[4]}}, semis});
		if (n_sum < signed'({3'b000, mcnr_pkg::NOTE_MIN})) begin
			note = mcnr_pkg::NOTE_MIN;
		end else if (n_sum > signed'({3'b000, mcnr_pkg::NOTE_MAX})) begin
			note = mcnr_pkg::NOTE_MAX;
		end else begin
			note = n_sum[6:0];
		end
	end

	assign chan    = lane_chan[lane];
	assign rd_addr = mcnr_pkg::ADDR_W'({lane, note});

	always_ff @(posedge clk) begin
		if (load) begin
			req_s1.cmd      <= s_tuser;
			req_s1.lane_ok  <= (32'(lane) < mcnr_pkg::LANES);
			req_s1.audible  <= ~chan[4];
			req_s1.chan     <= chan[3:0];
			req_s1.note     <= note;
			req_s1.addr     <= rd_addr;
			req_s1.product  <= 15'(velocity_scale) * 15'(padv);
			req_s1.offs_sum <= signed'({voff[7], voff}) + signed'({vrnd[7], vrnd});
		end
	end

endmodule

// ----- design/mcnr_msg_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcnr_msg_fifo
// Small message queue toward the master side; takes up to two messages per
// cycle and flags when two more fit.
// ----------------------------------------------------------------------------
module mcnr_msg_fifo (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [1:0]                        push_n,
	input  mcnr_pkg::msg_t                    push_a,
	input  mcnr_pkg::msg_t                    push_b,
	output logic                              room2,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [mcnr_pkg::OUT_DATA_W-1:0]   m_tdata, // status[7:0] note[14:8] velocity[21:15]
	output logic                              m_tlast
);

	mcnr_pkg::msg_t                  buf_q [mcnr_pkg::FIFO_DEPTH];
	logic [mcnr_pkg::FIFO_PTR_W-1:0] wr_ptr_q;
	logic [mcnr_pkg::FIFO_PTR_W-1:0] rd_ptr_q;
	logic [mcnr_pkg::FIFO_CNT_W-1:0] count_q;
	logic [mcnr_pkg::FIFO_PTR_W-1:0] wr_ptr_b;
	logic                            pop;
	mcnr_pkg::msg_t                  head;

	assign head     = buf_q[rd_ptr_q];
	assign m_tvalid = (count_q != '0);
	assign m_tdata  = {2'b00, head.velocity, head.note, head.status};
	assign m_tlast  = head.last;
	assign pop      = m_tvalid & m_tready;
	assign room2    = (count_q <= mcnr_pkg::FIFO_CNT_W'(mcnr_pkg::FIFO_DEPTH - 2));
	assign wr_ptr_b = wr_ptr_q + mcnr_pkg::FIFO_PTR_W'(1);

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			buf_q[wr_ptr_q] <= push_a;
		end
		if (push_n == 2'd2) begin
			buf_q[wr_ptr_b] <= push_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + mcnr_pkg::FIFO_PTR_W'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + mcnr_pkg::FIFO_PTR_W'(1);
			end
			count_q <= count_q + mcnr_pkg::FIFO_CNT_W'(push_n)
				- mcnr_pkg::FIFO_CNT_W'(pop);
		end
	end

endmodule

// ----- design/mcnr_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcnr_checker
// Port-level checks of the chord-note reference counter.
// ----------------------------------------------------------------------------
module mcnr_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [mcnr_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic                            m_tlast
);

	// one request in flight: no accept right after an accept
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted during counter update");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled message changed");

	a_status_form: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[7] && (m_tdata[6:5] == 2'b00) && (m_tdata[14:8] >= 7'd12))
		else $error("malformed status or note out of range");

	a_note_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[4] |-> m_tlast)
		else $error("note-on not marked last");

	// leading non-last message is followed at once by a last message of the same note
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=>
			m_tvalid && m_tlast && (m_tdata[14:8] == $past(m_tdata[14:8])))
		else $error("retrigger pair broken");

endmodule

bind midi_chord_note_refcount mcnr_checker u_checker (.*);

// ----- sim/chord_check_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chord_check_pkg
// Scoreboard for the chord-note reference counter. It tracks the sounding
// count of every lane and note and the register settings. From each accepted
// request it builds the MIDI messages the block must send. It then checks
// the sent messages against them in order.
// ----------------------------------------------------------------------------
package chord_check_pkg;

	import mcnr_pkg::*;

	class chord_scoreboard;

		logic [7:0] sounding [DEPTH];
		logic [6:0] root;
		logic [7:0] scale;
		logic [4:0] chan [CHAN_REGS];
		msg_t       expected [$];
		int         errors;

		function new();
			foreach (sounding[i])
				sounding[i] = '0;
			root    = 7'd60;
			scale   = 8'd64;
			chan[0] = 5'd0;
			chan[1] = 5'd1;
			chan[2] = 5'd2;
			chan[3] = 5'd3;
			errors  = 0;
		endfunction

		function int pending();
			return expected.size();
		endfunction

		task report(string what);
			if (errors < 40)
				$display("%0t: mismatch: %s", $time, what);
			errors++;
		endtask

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_ROOT_NOTE: root = val[6:0];
				REG_VEL_SCALE: scale = val;
				REG_LANE0_CH:  chan[0] = val[4:0];
				REG_LANE1_CH:  chan[1] = val[4:0];
				REG_LANE2_CH:  chan[2] = val[4:0];
				REG_LANE3_CH:  chan[3] = val[4:0];
				default: ;
			endcase
		endfunction

		// d: lane[1:0] interval[8:2] octave[12:9] semitone[17:13]
		//    pad_velocity[24:18] velocity_offset[32:25] random_offset[40:33]
		function void note_request(logic cmd, logic [IN_DATA_W-1:0] d);
			logic [1:0]        lane;
			int                pitch;
			int                vsum;
			logic [6:0]        vel;
			logic [ADDR_W-1:0] addr;
			logic [4:0]        ch;
			logic              audible;
			msg_t              m;
			lane = d[1:0];
			if (int'(lane) >= LANES)
				return;
			pitch = int'(root) + int'($signed(d[8:2])) + 12 * int'($signed(d[12:9]))
				+ int'($signed(d[17:13]));
			if (pitch < int'(NOTE_MIN))
				pitch = int'(NOTE_MIN);
			if (pitch > int'(NOTE_MAX))
				pitch = int'(NOTE_MAX);
			ch      = chan[lane];
			audible = !ch[4];
			addr    = ADDR_W'(int'(lane) * NOTES + pitch);
			m.note  = 7'(pitch);
			if (cmd == CMD_PLAY) begin
				vsum = int'(scale) * int'(d[24:18])
					+ (int'($signed(d[32:25])) + int'($signed(d[40:33]))) * 64;
				if (vsum < 64)
					vel = VEL_MIN;
				else if ((vsum >> 6) > int'(VEL_MAX))
					vel = VEL_MAX;
				else
					vel = 7'(vsum >> 6);
				m.velocity = vel;
				if (sounding[addr] != 8'd0 && audible) begin
					m.status = NOTE_OFF_STATUS | 8'(ch);
					m.last   = 1'b0;
					expected.push_back(m);
				end
				if (sounding[addr] != CNT_MAX)
					sounding[addr] = sounding[addr] + 8'd1;
				if (audible) begin
					m.status = NOTE_ON_STATUS | 8'(ch);
					m.last   = 1'b1;
					expected.push_back(m);
				end
			end else if (sounding[addr] != 8'd0) begin
				sounding[addr] = sounding[addr] - 8'd1;
				if (sounding[addr] == 8'd0 && audible) begin
					m.status   = NOTE_OFF_STATUS | 8'(ch);
					m.velocity = '0;
					m.last     = 1'b1;
					expected.push_back(m);
				end
			end
		endfunction

		task check_message(logic [OUT_DATA_W-1:0] d, logic last);
			msg_t want;
			if (expected.size() == 0) begin
				report($sformatf("unexpected message %h last %b", d, last));
				return;
			end
			want = expected.pop_front();
			if (d[7:0] !== want.status)
				report($sformatf("status %h, want %h", d[7:0], want.status));
			if (d[14:8] !== want.note)
				report($sformatf("note %0d, want %0d", d[14:8], want.note));
			if (d[21:15] !== want.velocity)
				report($sformatf("velocity %0d, want %0d", d[21:15], want.velocity));
			if (last !== want.last)
				report($sformatf("tlast %b, want %b", last, want.last));
		endtask

	endclass

endpackage

// ----- sim/tb_midi_chord_note_refcount.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_midi_chord_note_refcount
// Regression for the chord-note reference counter. Directed requests cover
// the note and velocity clamps, retrigger, stop to silence, muted lanes and
// stops of silent notes. Random phases follow under several register
// settings and idle patterns, plus a long output hold-off and a burst that
// saturates one note count. A scoreboard predicts and checks every message.
// ----------------------------------------------------------------------------
module tb_midi_chord_note_refcount;

	import mcnr_pkg::*;
	import chord_check_pkg::*;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata   = '0;
	logic                  s_tuser   = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;

	int gap_pct   = 0;
	int stall_pct = 0;
	int hold_left = 0;

	chord_scoreboard sb;

	midi_chord_note_refcount dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// output side: random stalls, or a counted hold-off
	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left = hold_left - 1;
		end else
			m_tready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				sb.write_reg(cfg_index, cfg_data);
			if (s_tvalid && s_tready)
				sb.note_request(s_tuser, s_tdata);
			if (m_tvalid && m_tready)
				sb.check_message(m_tdata, m_tlast);
		end
	end

	function automatic logic [IN_DATA_W-1:0] pack_req(int lane, int ivl, int oct, int semi,
		int padv, int voff, int vrnd);
		return {7'd0, 8'(vrnd), 8'(voff), 7'(padv), 5'(semi), 4'(oct), 7'(ivl), 2'(lane)};
	endfunction

	task automatic send_req(logic cmd, logic [IN_DATA_W-1:0] d);
		while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= d;
		do @(posedge clk); while (s_tready !== 1'b1);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		for (int i = 0; i < 4000 && sb.pending() != 0; i++)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic configure(int root, int scale, int c0, int c1, int c2, int c3);
		logic [CFG_IDX_W-1:0]  regs [6];
		logic [CFG_DATA_W-1:0] vals [6];
		regs = '{REG_ROOT_NOTE, REG_VEL_SCALE, REG_LANE0_CH, REG_LANE1_CH,
			REG_LANE2_CH, REG_LANE3_CH};
		vals = '{8'(root), 8'(scale), 8'(c0), 8'(c1), 8'(c2), 8'(c3)};
		for (int i = 0; i < 6; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= regs[i];
			cfg_data  <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// mostly chord-like requests on a small set of notes, some raw noise
	task automatic make_request(output logic cmd, output logic [IN_DATA_W-1:0] d);
		if ($urandom_range(99) < 15) begin
			cmd = 1'($urandom);
			d   = {7'd0, 9'($urandom), 32'($urandom)};
		end else begin
			cmd = ($urandom_range(99) < 55) ? CMD_PLAY : CMD_STOP;
			d   = pack_req($urandom_range(3), $urandom_range(11),
				int'($urandom_range(2)) - 1,
				($urandom_range(3) == 0) ? int'($urandom_range(4)) - 2 : 0,
				$urandom_range(127), int'($urandom_range(40)) - 20,
				int'($urandom_range(20)) - 10);
		end
	endtask

	task automatic run_phase(int n, int gap, int stall, int hold_at);
		logic                 cmd;
		logic [IN_DATA_W-1:0] d;
		gap_pct   = gap;
		stall_pct = stall;
		for (int i = 0; i < n; i++) begin
			if (i == hold_at)
				hold_left = 400;
			make_request(cmd, d);
			send_req(cmd, d);
		end
		settle();
	endtask

	// drive one note past the 255 count limit, then back to silence
	task automatic saturate_note(int gap, int stall);
		gap_pct   = gap;
		stall_pct = stall;
		for (int i = 0; i < 258; i++)
			send_req(CMD_PLAY, pack_req(0, 7, 0, 0, $urandom_range(127),
				int'($urandom_range(60)) - 30, int'($urandom_range(60)) - 30));
		for (int i = 0; i < 257; i++)
			send_req(CMD_STOP, pack_req(0, 7, 0, 0, $urandom_range(127), 0, 0));
		settle();
	endtask

	initial begin
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		do @(posedge clk); while (s_tready !== 1'b1);

		// retrigger, stop to silence, stop of a silent note
		send_req(CMD_PLAY, pack_req(0, 0, 0, 0, 127, 0, 0));
		send_req(CMD_PLAY, pack_req(0, 0, 0, 0, 0, -128, -128));
		send_req(CMD_STOP, pack_req(0, 0, 0, 0, 0, 0, 0));
		send_req(CMD_STOP, pack_req(0, 0, 0, 0, 0, 0, 0));
		send_req(CMD_STOP, pack_req(0, 0, 0, 0, 0, 0, 0));
		// note clamps at both ends, velocity clamps
		send_req(CMD_PLAY, pack_req(1, -64, -8, -16, 5, 0, 0));
		send_req(CMD_PLAY, pack_req(2, 63, 7, 15, 127, 127, 127));
		send_req(CMD_PLAY, pack_req(3, 4, 1, -1, 64, -10, 3));
		send_req(CMD_STOP, pack_req(1, -64, -8, -16, 0, 0, 0));
		send_req(CMD_STOP, pack_req(2, 63, 7, 15, 0, 0, 0));
		send_req(CMD_STOP, pack_req(3, 4, 1, -1, 0, 0, 0));
		send_req(CMD_PLAY, pack_req(0, 0, 0, 0, 1, 0, 0));
		send_req(CMD_PLAY, pack_req(0, 0, 0, 0, 2, 0, -1));
		send_req(CMD_STOP, pack_req(0, 0, 0, 0, 0, 0, 0));
		send_req(CMD_STOP, pack_req(0, 0, 0, 0, 0, 0, 0));
		settle();

		// muted lanes, lowest root, highest gain
		configure(0, 255, 16, 0, 15, 31);
		send_req(CMD_PLAY, pack_req(0, 0, 0, 0, 100, 0, 0));
		send_req(CMD_PLAY, pack_req(0, 0, 0, 0, 100, 0, 0));
		send_req(CMD_STOP, pack_req(0, 0, 0, 0, 0, 0, 0));
		send_req(CMD_STOP, pack_req(0, 0, 0, 0, 0, 0, 0));
		send_req(CMD_PLAY, pack_req(1, 0, 0, 0, 127, 0, 0));
		send_req(CMD_PLAY, pack_req(2, 0, 0, 0, 1, 0, 0));
		send_req(CMD_STOP, pack_req(1, 0, 0, 0, 0, 0, 0));
		send_req(CMD_STOP, pack_req(2, 0, 0, 0, 0, 0, 0));
		send_req(CMD_PLAY, pack_req(3, 0, 0, 0, 0, 0, 0));
		send_req(CMD_STOP, pack_req(3, 0, 0, 0, 0, 0, 0));
		settle();

		configure(60, 64, 0, 1, 2, 3);
		run_phase(280, 0, 0, -1);
		configure(127, 0, 15, 16, 9, 4);
		run_phase(250, 64, 0, -1);
		configure(0, 255, 5, 6, 31, 15);
		run_phase(250, 0, 64, 100);
		configure(48, 100, 10, 11, 12, 13);
		run_phase(250, 33, 33, -1);
		configure(60, 64, 0, 1, 2, 3);
		saturate_note(0, 33);

		if (sb.pending() != 0)
			sb.report($sformatf("%0d messages never arrived", sb.pending()));
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#(12 * 300000);
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
